// File: design/pklc_pkg.sv
package pklc_pkg;

   localparam int WAYS = 4;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   localparam logic [3:0] FMT_PAL_BASE = 4'd8;
   localparam logic [3:0] FMT_OTHER_BASE = 4'd12;
   localparam logic [2:0] STRIDE_BYTES_PAL = 3'd4;
   localparam logic [2:0] DEPTH_DEEP = 3'b111;

   typedef enum logic [1:0] {
      CMD_BYTE = 2'd0,
      CMD_END  = 2'd1,
      CMD_NONE = 2'd2,
      CMD_RSVD = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_HIT   = 2'd0,
      ST_FILL  = 2'd1,
      ST_UNSUP = 2'd2,
      ST_NOPAL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ORD_BGR = 2'd0,
      ORD_RGB = 2'd1,
      ORD_XBGR = 2'd2,
      ORD_XRGB = 2'd3
   } order_type;

   typedef struct packed {
      logic       supported;
      logic [2:0] red_bits;
      logic [2:0] green_bits;
      logic [2:0] blue_bits;
      logic [4:0] red_shift;
      logic [4:0] green_shift;
      logic [4:0] blue_shift;
      logic [2:0] stride_bytes;
      logic [2:0] dest_depth_log2;
   } layout_type;

   // x * 0x01000193 as shift-add
   function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] x;
      x = h ^ {24'd0, b};
      return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
   endfunction

   function automatic logic fmt_deep(input logic [3:0] f);
      return f < FMT_PAL_BASE;
   endfunction

   function automatic logic fmt_pal(input logic [3:0] f);
      return (f >= FMT_PAL_BASE) && (f < FMT_OTHER_BASE);
   endfunction

   function automatic layout_type make_layout(input logic [3:0] src, input logic [3:0] dst);
      layout_type l;
      logic [3:0] lg;
      l = '0;
      l.dest_depth_log2 = DEPTH_DEEP;
      lg = dst - FMT_PAL_BASE;
      if (fmt_deep(src) && fmt_pal(dst)) begin
         l.supported = 1'b1;
         if (lg == 4'd3) begin
            l.red_bits = 3'd5;
            l.green_bits = 3'd6;
            l.blue_bits = 3'd5;
         end else begin
            l.red_bits = 3'd4;
            l.green_bits = 3'd4;
            l.blue_bits = 3'd4;
         end
         unique case (order_type'(src[1:0]))
            ORD_BGR: begin
               l.red_shift = 5'd16; l.green_shift = 5'd8; l.blue_shift = 5'd0;
            end
            ORD_RGB: begin
               l.red_shift = 5'd0; l.green_shift = 5'd8; l.blue_shift = 5'd16;
            end
            ORD_XBGR: begin
               l.red_shift = 5'd24; l.green_shift = 5'd16; l.blue_shift = 5'd8;
            end
            ORD_XRGB: begin
               l.red_shift = 5'd8; l.green_shift = 5'd16; l.blue_shift = 5'd24;
            end
            default: begin
               l.red_shift = 5'd0; l.green_shift = 5'd0; l.blue_shift = 5'd0;
            end
         endcase
         l.dest_depth_log2 = lg[2:0];
      end else if (fmt_pal(src) && fmt_deep(dst)) begin
         l.supported = 1'b1;
         l.stride_bytes = STRIDE_BYTES_PAL;
      end
      return l;
   endfunction

endpackage

// File: design/palette_keyed_lru_map_cache_core.sv
// End and none beats reach their result strobe via the input register, then the result register.
// Throughput: one beat per cycle; busy is never raised. The hash fold (constant shift-add
// multiply), the per-way tag compares and the recency victim search all sit in one stage.
// Results cannot be stalled by the receiver.
// Reset (synchronous, active high) restarts the hash, clears all way valid bits and the use clock.
module palette_keyed_lru_map_cache_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_cmd,
   input  logic [7:0]        req_palette_byte,
   input  logic [3:0]        req_src_format,
   input  logic [3:0]        req_dst_format,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [1:0]        rsp_slot,
   output logic [31:0]       rsp_palette_hash,
   output logic [2:0]        rsp_red_bits,
   output logic [2:0]        rsp_green_bits,
   output logic [2:0]        rsp_blue_bits,
   output logic [4:0]        rsp_red_shift,
   output logic [4:0]        rsp_green_shift,
   output logic [4:0]        rsp_blue_shift,
   output logic [2:0]        rsp_stride_bytes,
   output logic signed [2:0] rsp_dest_depth_log2
);

   localparam int WAYS = pklc_pkg::WAYS;
   localparam int WAY_W = pklc_pkg::WAY_W;

   // input register
   logic                 req_vld_ff;
   pklc_pkg::cmd_type    cmd_ff;
   logic [7:0]           byte_ff;
   logic [3:0]           src_ff;
   logic [3:0]           dst_ff;

   // state
   logic [31:0]          hash_ff, hash_in;
   logic [31:0]          clk_ff, clk_in;
   logic [WAYS-1:0]      valid_ff, valid_in;
   logic [3:0]           wsrc_ff [WAYS];
   logic [3:0]           wdst_ff [WAYS];
   logic [31:0]          whash_ff [WAYS];
   logic [31:0]          wstamp_ff [WAYS];

   // result register
   logic                 rsp_vld_ff, rsp_vld_in;
   pklc_pkg::status_type status_ff, status_in;
   logic [1:0]           slot_ff, slot_in;
   logic [31:0]          phash_ff, phash_in;
   pklc_pkg::layout_type lay_ff, lay_in;

   // lookup
   pklc_pkg::layout_type lay;
   logic                 hit;
   logic [WAY_W-1:0]     hit_idx;
   logic                 free_found;
   logic [WAY_W-1:0]     victim;
   logic [31:0]          oldest;
   logic                 wr_en;
   logic [WAY_W-1:0]     wr_idx;
   logic [31:0]          clk_inc;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= start;
      end
      cmd_ff  <= pklc_pkg::cmd_type'(req_cmd);
      byte_ff <= req_palette_byte;
      src_ff  <= req_src_format;
      dst_ff  <= req_dst_format;
   end

   always_comb begin
      lay = pklc_pkg::make_layout(src_ff, dst_ff);
      clk_inc = clk_ff + 32'd1;

      hit = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (!hit && valid_ff[i] && wsrc_ff[i] == src_ff && wdst_ff[i] == dst_ff &&
             whash_ff[i] == hash_ff) begin
            hit = 1'b1;
            hit_idx = WAY_W'(i);
         end
      end

      free_found = 1'b0;
      victim = '0;
      oldest = valid_ff[0] ? wstamp_ff[0] : 32'd0;
      for (int i = 0; i < WAYS; i++) begin
         if (!free_found) begin
            if (!valid_ff[i]) begin
               free_found = 1'b1;
               victim = WAY_W'(i);
            end else if (wstamp_ff[i] < oldest) begin
               oldest = wstamp_ff[i];
               victim = WAY_W'(i);
            end
         end
      end

      hash_in = hash_ff;
      clk_in = clk_ff;
      valid_in = valid_ff;
      wr_en = 1'b0;
      wr_idx = victim;
      rsp_vld_in = 1'b0;
      status_in = pklc_pkg::ST_NOPAL;
      slot_in = '0;
      phash_in = '0;
      lay_in = pklc_pkg::make_layout(4'd0, 4'd0);

      if (req_vld_ff) begin
         unique case (cmd_ff)
            pklc_pkg::CMD_BYTE: begin
               hash_in = pklc_pkg::fnv_step(hash_ff, byte_ff);
            end
            pklc_pkg::CMD_END: begin
               hash_in = pklc_pkg::FNV_BASIS;
               rsp_vld_in = 1'b1;
               phash_in = hash_ff;
               lay_in = lay;
               if (hit) begin
                  status_in = pklc_pkg::ST_HIT;
                  slot_in = 2'(hit_idx);
                  clk_in = clk_inc;
                  wr_idx = hit_idx;
               end else if (lay.supported) begin
                  status_in = pklc_pkg::ST_FILL;
                  slot_in = 2'(victim);
                  clk_in = clk_inc;
                  valid_in[victim] = 1'b1;
                  wr_en = 1'b1;
               end else begin
                  status_in = pklc_pkg::ST_UNSUP;
                  valid_in[victim] = 1'b0;
               end
            end
            pklc_pkg::CMD_NONE: begin
               hash_in = pklc_pkg::FNV_BASIS;
               rsp_vld_in = 1'b1;
               status_in = pklc_pkg::ST_NOPAL;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= pklc_pkg::FNV_BASIS;
         clk_ff <= '0;
         valid_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         clk_ff <= clk_in;
         valid_ff <= valid_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      if (wr_en) begin
         wsrc_ff[wr_idx] <= src_ff;
         wdst_ff[wr_idx] <= dst_ff;
         whash_ff[wr_idx] <= hash_ff;
      end
      if (clk_in != clk_ff) begin
         wstamp_ff[wr_idx] <= clk_in;
      end
      status_ff <= status_in;
      slot_ff <= slot_in;
      phash_ff <= phash_in;
      lay_ff <= lay_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_status = status_ff;
   assign rsp_slot = slot_ff;
   assign rsp_palette_hash = phash_ff;
   assign rsp_red_bits = lay_ff.red_bits;
   assign rsp_green_bits = lay_ff.green_bits;
   assign rsp_blue_bits = lay_ff.blue_bits;
   assign rsp_red_shift = lay_ff.red_shift;
   assign rsp_green_shift = lay_ff.green_shift;
   assign rsp_blue_shift = lay_ff.blue_shift;
   assign rsp_stride_bytes = lay_ff.stride_bytes;
   assign rsp_dest_depth_log2 = $signed(lay_ff.dest_depth_log2);

endmodule

// File: bench/palette_keyed_lru_map_cache_core_tb.sv
module palette_keyed_lru_map_cache_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] FMT_BGRX = 4'd0;
   localparam logic [3:0] FMT_RGBX = 4'd1;
   localparam logic [3:0] FMT_XBGR = 4'd2;
   localparam logic [3:0] FMT_XRGB = 4'd3;
   localparam logic [3:0] FMT_BGRA = 4'd4;
   localparam logic [3:0] FMT_RGBA = 4'd5;
   localparam logic [3:0] FMT_ABGR = 4'd6;
   localparam logic [3:0] FMT_ARGB = 4'd7;
   localparam logic [3:0] FMT_P1 = 4'd8;
   localparam logic [3:0] FMT_P2 = 4'd9;
   localparam logic [3:0] FMT_P4 = 4'd10;
   localparam logic [3:0] FMT_P8 = 4'd11;
   localparam logic [3:0] FMT_OTHER = 4'd12;
   localparam logic [3:0] FMT_OTHER_LAST = 4'd15;

   localparam int TARGET_BEATS = 1000;
   localparam int STALL_LIMIT = 500;
   localparam int POOL_SIZE = 6;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  slot;
      logic [31:0] hash;
      logic [2:0]  red_bits;
      logic [2:0]  green_bits;
      logic [2:0]  blue_bits;
      logic [4:0]  red_shift;
      logic [4:0]  green_shift;
      logic [4:0]  blue_shift;
      logic [2:0]  stride_bytes;
      logic [2:0]  depth_log2;
   } layout_beat;

   class layout_scoreboard;
      logic [31:0] run_hash;
      bit          way_ok[pklc_pkg::WAYS];
      logic [3:0]  way_src[pklc_pkg::WAYS];
      logic [3:0]  way_dst[pklc_pkg::WAYS];
      logic [31:0] way_hash[pklc_pkg::WAYS];
      logic [31:0] way_stamp[pklc_pkg::WAYS];
      logic [31:0] use_clock;
      layout_beat  pending_layouts[$];
      int          mismatches;
      int          n_hit;
      int          n_fill;
      int          n_unsup;
      int          n_nopal;

      function new();
         run_hash = pklc_pkg::FNV_BASIS;
         use_clock = '0;
         for (int i = 0; i < pklc_pkg::WAYS; i++) begin
            way_ok[i] = 1'b0;
            way_src[i] = '0;
            way_dst[i] = '0;
            way_hash[i] = '0;
            way_stamp[i] = '0;
         end
      endfunction

      function int pending_count();
         return pending_layouts.size();
      endfunction

      function bit derive_layout(input logic [3:0] s, input logic [3:0] d,
                                 output layout_beat r);
         logic [3:0] lg;
         r = '0;
         r.depth_log2 = pklc_pkg::DEPTH_DEEP;
         lg = d - pklc_pkg::FMT_PAL_BASE;
         if (s < pklc_pkg::FMT_PAL_BASE && d >= pklc_pkg::FMT_PAL_BASE &&
             d < pklc_pkg::FMT_OTHER_BASE) begin
            if (d == FMT_P8) {r.red_bits, r.green_bits, r.blue_bits} = {3'd5, 3'd6, 3'd5};
            else {r.red_bits, r.green_bits, r.blue_bits} = {3'd4, 3'd4, 3'd4};
            case (pklc_pkg::order_type'(s[1:0]))
               pklc_pkg::ORD_BGR:
                  {r.red_shift, r.green_shift, r.blue_shift} = {5'd16, 5'd8, 5'd0};
               pklc_pkg::ORD_RGB:
                  {r.red_shift, r.green_shift, r.blue_shift} = {5'd0, 5'd8, 5'd16};
               pklc_pkg::ORD_XBGR:
                  {r.red_shift, r.green_shift, r.blue_shift} = {5'd24, 5'd16, 5'd8};
               default:
                  {r.red_shift, r.green_shift, r.blue_shift} = {5'd8, 5'd16, 5'd24};
            endcase
            r.depth_log2 = lg[2:0];
            return 1'b1;
         end
         if (s >= pklc_pkg::FMT_PAL_BASE && s < pklc_pkg::FMT_OTHER_BASE &&
             d < pklc_pkg::FMT_PAL_BASE) begin
            r.stride_bytes = pklc_pkg::STRIDE_BYTES_PAL;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_beat(input pklc_pkg::cmd_type c, input logic [7:0] b,
                              input logic [3:0] s, input logic [3:0] d);
         layout_beat  r;
         logic [31:0] h;
         logic [31:0] oldest;
         int          victim;
         if (c == pklc_pkg::CMD_BYTE) begin
            run_hash = (run_hash ^ {24'd0, b}) * pklc_pkg::FNV_PRIME;
            return;
         end
         if (c == pklc_pkg::CMD_RSVD) return;
         h = run_hash;
         run_hash = pklc_pkg::FNV_BASIS;
         if (c == pklc_pkg::CMD_NONE) begin
            void'(derive_layout(FMT_OTHER_LAST, FMT_OTHER_LAST, r));
            r.status = pklc_pkg::ST_NOPAL;
            n_nopal++;
            pending_layouts.push_back(r);
            return;
         end
         for (int i = 0; i < pklc_pkg::WAYS; i++) begin
            if (way_ok[i] && way_src[i] == s && way_dst[i] == d && way_hash[i] == h) begin
               use_clock++;
               way_stamp[i] = use_clock;
               void'(derive_layout(s, d, r));
               r.status = pklc_pkg::ST_HIT;
               r.slot = pklc_pkg::WAY_W'(i);
               r.hash = h;
               n_hit++;
               pending_layouts.push_back(r);
               return;
            end
         end
         victim = 0;
         oldest = way_ok[0] ? way_stamp[0] : 32'd0;
         for (int i = 0; i < pklc_pkg::WAYS; i++) begin
            if (!way_ok[i]) begin
               victim = i;
               break;
            end
            if (way_stamp[i] < oldest) begin
               oldest = way_stamp[i];
               victim = i;
            end
         end
         way_ok[victim] = 1'b0;
         if (!derive_layout(s, d, r)) begin
            r.status = pklc_pkg::ST_UNSUP;
            r.hash = h;
            n_unsup++;
            pending_layouts.push_back(r);
            return;
         end
         way_ok[victim] = 1'b1;
         way_src[victim] = s;
         way_dst[victim] = d;
         way_hash[victim] = h;
         use_clock++;
         way_stamp[victim] = use_clock;
         r.status = pklc_pkg::ST_FILL;
         r.slot = pklc_pkg::WAY_W'(victim);
         r.hash = h;
         n_fill++;
         pending_layouts.push_back(r);
      endfunction

      function string describe(input layout_beat r);
         return $sformatf({"status %0d slot %0d hash %h bits %0d/%0d/%0d",
                           " shifts %0d/%0d/%0d stride %0d depth %0d"},
                          r.status, r.slot, r.hash, r.red_bits, r.green_bits, r.blue_bits,
                          r.red_shift, r.green_shift, r.blue_shift, r.stride_bytes,
                          $signed(r.depth_log2));
      endfunction

      function void check_result(input layout_beat got);
         layout_beat want;
         if (pending_layouts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %s", describe(got));
            return;
         end
         want = pending_layouts.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch at %0t", $time);
               $display("  expected %s", describe(want));
               $display("  actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd = pklc_pkg::CMD_BYTE;
   logic [7:0]  req_palette_byte = '0;
   logic [3:0]  req_src_format = '0;
   logic [3:0]  req_dst_format = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_slot;
   logic [31:0] rsp_palette_hash;
   logic [2:0]  rsp_red_bits;
   logic [2:0]  rsp_green_bits;
   logic [2:0]  rsp_blue_bits;
   logic [4:0]  rsp_red_shift;
   logic [4:0]  rsp_green_shift;
   logic [4:0]  rsp_blue_shift;
   logic [2:0]  rsp_stride_bytes;
   logic signed [2:0] rsp_dest_depth_log2;

   layout_scoreboard cache_sb;
   bit          idle_on;
   int          beats;
   int          stall_cycles;
   logic [31:0] pool_seed[POOL_SIZE];
   int          pool_len[POOL_SIZE];
   logic [3:0]  pool_src[POOL_SIZE];
   logic [3:0]  pool_dst[POOL_SIZE];

   palette_keyed_lru_map_cache_core dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      layout_beat got;
      if (!reset) begin
         if (rsp_valid) begin
            got = {rsp_status, rsp_slot, rsp_palette_hash, rsp_red_bits, rsp_green_bits,
                   rsp_blue_bits, rsp_red_shift, rsp_green_shift, rsp_blue_shift,
                   rsp_stride_bytes, rsp_dest_depth_log2};
            cache_sb.check_result(got);
         end
         if (start && !busy)
            cache_sb.note_beat(pklc_pkg::cmd_type'(req_cmd), req_palette_byte,
                               req_src_format, req_dst_format);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("palette_keyed_lru_map_cache_core regression: fail");
         $finish;
      end
   end

   task automatic send_beat(input pklc_pkg::cmd_type c, input logic [7:0] b,
                            input logic [3:0] s, input logic [3:0] d);
      int gap;
      gap = idle_on ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= c;
      req_palette_byte <= b;
      req_src_format <= s;
      req_dst_format <= d;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (c != pklc_pkg::CMD_RSVD) beats++;
   endtask

   task automatic send_palette(input logic [31:0] seed, input int len);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 15) == 0)
            send_beat(pklc_pkg::CMD_RSVD, 8'($urandom), 4'($urandom), 4'($urandom));
         send_beat(pklc_pkg::CMD_BYTE, 8'(seed >> (8 * (k % 4))) ^ 8'(k * 37),
                   4'($urandom), 4'($urandom));
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (cache_sb.pending_count() > 0) @(posedge clock);
   endtask

   task automatic refresh_pool(input int k);
      pool_seed[k] = $urandom;
      pool_len[k] = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
      if ($urandom_range(0, 1) == 0) begin
         pool_src[k] = 4'($urandom_range(FMT_BGRX, FMT_ARGB));
         pool_dst[k] = 4'($urandom_range(FMT_P1, FMT_P8));
      end else begin
         pool_src[k] = 4'($urandom_range(FMT_P1, FMT_P8));
         pool_dst[k] = 4'($urandom_range(FMT_BGRX, FMT_ARGB));
      end
   endtask

   initial begin
      int  pick;
      int  k;
      bit  drained;
      cache_sb = new();
      idle_on = 1'b0;
      drained = 1'b0;
      beats = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty palette, hit, each order and depth, unsupported pairs
      send_beat(pklc_pkg::CMD_NONE, 8'hFF, FMT_OTHER_LAST, FMT_OTHER_LAST);
      send_beat(pklc_pkg::CMD_END, 8'h00, FMT_BGRX, FMT_P1);
      send_beat(pklc_pkg::CMD_END, 8'h00, FMT_BGRX, FMT_P1);
      send_beat(pklc_pkg::CMD_BYTE, 8'h00, FMT_BGRX, FMT_BGRX);
      send_beat(pklc_pkg::CMD_BYTE, 8'hFF, FMT_OTHER_LAST, FMT_OTHER_LAST);
      send_beat(pklc_pkg::CMD_END, 8'h00, FMT_ARGB, FMT_P8);
      send_beat(pklc_pkg::CMD_END, 8'h00, FMT_P1, FMT_BGRX);
      send_beat(pklc_pkg::CMD_END, 8'h00, FMT_BGRX, FMT_RGBX);
      send_beat(pklc_pkg::CMD_END, 8'h00, FMT_P2, FMT_P4);
      send_beat(pklc_pkg::CMD_END, 8'h00, FMT_OTHER, FMT_P1);
      send_beat(pklc_pkg::CMD_END, 8'h00, FMT_XRGB, FMT_OTHER_LAST);
      send_beat(pklc_pkg::CMD_END, 8'h00, FMT_OTHER_LAST, FMT_BGRA);
      send_beat(pklc_pkg::CMD_RSVD, 8'hAA, FMT_XRGB, FMT_XRGB);
      send_beat(pklc_pkg::CMD_BYTE, 8'h55, FMT_BGRX, FMT_BGRX);
      send_beat(pklc_pkg::CMD_END, 8'h00, FMT_RGBX, FMT_P4);
      send_beat(pklc_pkg::CMD_BYTE, 8'h12, FMT_BGRX, FMT_BGRX);
      send_beat(pklc_pkg::CMD_END, 8'h00, FMT_XBGR, FMT_P2);
      send_beat(pklc_pkg::CMD_END, 8'h00, FMT_BGRA, FMT_P1);
      send_beat(pklc_pkg::CMD_END, 8'h00, FMT_ABGR, FMT_P8);
      send_beat(pklc_pkg::CMD_END, 8'h00, FMT_RGBA, FMT_P2);
      send_beat(pklc_pkg::CMD_BYTE, 8'h80, FMT_BGRX, FMT_BGRX);
      send_beat(pklc_pkg::CMD_NONE, 8'h00, FMT_P8, FMT_ARGB);
      send_beat(pklc_pkg::CMD_END, 8'h00, FMT_P8, FMT_ARGB);
      send_beat(pklc_pkg::CMD_END, 8'h00, FMT_BGRX, FMT_P1);

      for (int i = 0; i < POOL_SIZE; i++) refresh_pool(i);
      idle_on = 1'b1;
      while (beats < TARGET_BEATS) begin
         if ($urandom_range(0, 15) == 0) idle_on = ($urandom_range(0, 2) != 0);
         if (!drained && beats >= TARGET_BEATS / 2) begin
            drain_results();
            drained = 1'b1;
         end
         pick = $urandom_range(0, 99);
         k = $urandom_range(0, POOL_SIZE - 1);
         if (pick < 70) begin
            if ($urandom_range(0, 9) == 0) refresh_pool(k);
            send_palette(pool_seed[k], pool_len[k]);
            send_beat(pklc_pkg::CMD_END, 8'($urandom), pool_src[k], pool_dst[k]);
         end else if (pick < 80) begin
            send_palette($urandom, $urandom_range(0, 5));
            send_beat(pklc_pkg::CMD_END, 8'($urandom), 4'($urandom), 4'($urandom));
         end else if (pick < 88) begin
            // broken sequence: palette cut short by a request without palette
            send_palette(pool_seed[k], $urandom_range(0, 3));
            send_beat(pklc_pkg::CMD_NONE, 8'($urandom), 4'($urandom), 4'($urandom));
         end else if (pick < 94) begin
            send_beat(pklc_pkg::CMD_RSVD, 8'($urandom), 4'($urandom), 4'($urandom));
         end else begin
            send_palette(pool_seed[k], pool_len[k]);
            send_beat(pklc_pkg::CMD_END, 8'($urandom), 4'($urandom), 4'($urandom));
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("%0d beats sent: %0d hits, %0d fills, %0d unsupported pairs, %0d without palette",
               beats, cache_sb.n_hit, cache_sb.n_fill, cache_sb.n_unsup, cache_sb.n_nopal);
      $display("%0d mismatches, %0d results still outstanding", cache_sb.mismatches,
               cache_sb.pending_count());
      if (cache_sb.mismatches == 0 && cache_sb.pending_count() == 0) begin
         $display("palette_keyed_lru_map_cache_core regression: pass");
      end else begin
         $display("palette_keyed_lru_map_cache_core regression: fail");
      end
      $finish;
   end

endmodule
